// File: rtl/core/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the paged address translator.
// ----------------------------------------------------------------------------
package pat_pkg;

  // field widths of a request and a response word
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PidW    = 4;
  localparam int unsigned PageW   = 5;
  localparam int unsigned ValueW  = 10;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 26;
  localparam int unsigned FrameW  = 10;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [OffsetW-1:0] PageSizeRst   = 16'd100;
  localparam logic [FrameW-1:0]  FrameCountRst = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_SIZE   = 2'd0,
    CFG_FRAME_COUNT = 2'd1
  } pat_cfg_idx_e;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_XLATE = 2'd2
  } pat_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } pat_status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_RESULT = 2'd2
  } pat_state_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [PidW-1:0]    process_id;
    logic [PageW-1:0]   page_number;
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] offset;
  } pat_item_t;

endpackage

// File: rtl/core/pat_req_if.sv
// ----------------------------------------------------------------------------
// pat_req_if
// Command channel: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface pat_req_if;
  logic                            valid;
  logic                            ready;
  logic [pat_pkg::CmdW-1:0]        cmd;
  logic [pat_pkg::PidW-1:0]        process_id;
  logic [pat_pkg::PageW-1:0]       page_number;
  logic [pat_pkg::ValueW-1:0]      value;
  logic [pat_pkg::OffsetW-1:0]     offset;

  modport source (output valid, cmd, process_id, page_number, value, offset, input ready);
  modport sink   (input valid, cmd, process_id, page_number, value, offset, output ready);
endinterface

// File: rtl/core/pat_rsp_if.sv
// ----------------------------------------------------------------------------
// pat_rsp_if
// Response channel: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface pat_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pat_pkg::StatusW-1:0]     status;
  logic [pat_pkg::AddrW-1:0]       physical_address;
  logic [pat_pkg::PidW-1:0]        assigned_process;

  modport source (output valid, status, physical_address, assigned_process, input ready);
  modport sink   (input valid, status, physical_address, assigned_process, output ready);
endinterface

// File: rtl/core/pat_cfg_if.sv
// ----------------------------------------------------------------------------
// pat_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface pat_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pat_pkg::CfgIdxW-1:0]     index;
  logic [pat_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pat_count_ram.sv
// ----------------------------------------------------------------------------
// pat_count_ram
// Page count per process. Sync RAM, registered read; per-entry valid bits
// so that never-written entries read as zero pages.
// ----------------------------------------------------------------------------
module pat_count_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned DataW = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i
);

  logic [DataW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [DataW-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/core/pat_frame_ram.sv
// ----------------------------------------------------------------------------
// pat_frame_ram
// Frame table. Plain sync RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module pat_frame_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned DataW = 10
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/paged_address_translator.sv
// ----------------------------------------------------------------------------
// paged_address_translator
// Per-process page table with allocate, entry write and address translate.
// ----------------------------------------------------------------------------
// One command is in flight at a time and passes an accept, a lookup and a
// result cycle: the accept cycle issues the reads of the page-count RAM and
// the frame RAM (the frame read is speculative, addressed from the incoming
// process and page), the lookup cycle checks the command against the read
// data, performs any table write and registers frame * page_size, and the
// result cycle adds the offset and loads the output register, waiting while
// that register holds a word the response side has not yet taken. A new
// command is taken in the cycle after that, so one command must be through
// before the next is taken. The output register lets the next command be
// accepted while a response word is still waiting. Because commands never
// overlap, a table write always lands before the next read of the same
// entry. Frame table entries are undefined until written; page counts read
// as zero until an allocate sets them. Registers: index 0 page_size, index 1
// frame_count; writing frame_count reloads the free-frame count until the
// first allocate has been granted or refused for lack of free frames.
// ----------------------------------------------------------------------------
module paged_address_translator #(
  parameter int unsigned MAX_PROCESSES         = 16,
  parameter int unsigned MAX_PAGES_PER_PROCESS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pat_req_if.sink  req_i,
  pat_rsp_if.source rsp_o,
  pat_cfg_if.sink  cfg_i
);

  localparam int unsigned ProcAw     = $clog2(MAX_PROCESSES);
  localparam int unsigned NextW      = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned CntW       = $clog2(MAX_PAGES_PER_PROCESS + 1);
  localparam int unsigned FrameDepth = MAX_PROCESSES * MAX_PAGES_PER_PROCESS;
  localparam int unsigned FrameAw    = $clog2(FrameDepth);
  localparam int unsigned ProdW      = pat_pkg::FrameW + pat_pkg::OffsetW;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  pat_pkg::pat_state_e                state_q, state_d;
  pat_pkg::pat_item_t                 item_q;
  logic [pat_pkg::OffsetW-1:0]        page_size_q;
  logic [pat_pkg::FrameW-1:0]         frames_left_q, frames_left_d;
  logic [NextW-1:0]                   next_q, next_d;
  logic                               full_q, full_d;
  logic                               touched_q, touched_d;

  // result of the lookup cycle
  pat_pkg::pat_status_e               status_q, status_d;
  logic                               xl_ok_q, xl_ok_d;
  logic [pat_pkg::PidW-1:0]           assigned_q, assigned_d;
  logic [ProdW-1:0]                   prod_q;

  // output register
  logic                               out_vld_q;
  logic [pat_pkg::StatusW-1:0]        out_status_q;
  logic [pat_pkg::AddrW-1:0]          out_addr_q;
  logic [pat_pkg::PidW-1:0]           out_assigned_q;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  logic req_fire;
  logic rsp_fire;
  logic cfg_fire;
  logic out_load;

  assign req_i.ready = (state_q == pat_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_load    = (state_q == pat_pkg::S_RESULT) && (!out_vld_q || rsp_o.ready);

  // --------------------------------------------------------------------------
  // tables
  // --------------------------------------------------------------------------
  logic [ProcAw-1:0]          cnt_raddr;
  logic [CntW-1:0]            cnt_rdata;
  logic                       cnt_we;
  logic [FrameAw-1:0]         frm_raddr;
  logic [FrameAw-1:0]         frm_waddr;
  logic [pat_pkg::FrameW-1:0] frm_rdata;
  logic                       frm_we;

  assign cnt_raddr = ProcAw'(req_i.process_id);
  // entry index: process * pages-per-process + page
  assign frm_raddr = FrameAw'(32'(req_i.process_id) * 32'(MAX_PAGES_PER_PROCESS)
                              + 32'(req_i.page_number));
  assign frm_waddr = FrameAw'(32'(item_q.process_id) * 32'(MAX_PAGES_PER_PROCESS)
                              + 32'(item_q.page_number));

  pat_count_ram #(
    .Depth (MAX_PROCESSES),
    .DataW (CntW)
  ) u_count_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (req_fire),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata),
    .we_i    (cnt_we),
    .waddr_i (next_q[ProcAw-1:0]),
    .wdata_i (CntW'(item_q.value))
  );

  pat_frame_ram #(
    .Depth (FrameDepth),
    .DataW (pat_pkg::FrameW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .re_i    (req_fire),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (item_q.value)
  );

  // --------------------------------------------------------------------------
  // lookup checks
  // --------------------------------------------------------------------------
  logic pid_ok;
  logic page_ok;
  logic off_ok;
  logic slots_gone;
  logic too_big;
  logic no_frames;

  assign pid_ok     = 32'(item_q.process_id) < 32'(MAX_PROCESSES);
  assign page_ok    = 32'(item_q.page_number) < 32'(cnt_rdata);
  assign off_ok     = item_q.offset < page_size_q;
  assign slots_gone = full_q || (next_q == NextW'(MAX_PROCESSES));
  assign too_big    = 32'(item_q.value) > 32'(MAX_PAGES_PER_PROCESS);
  assign no_frames  = item_q.value > frames_left_q;

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    frames_left_d = frames_left_q;
    next_d        = next_q;
    full_d        = full_q;
    touched_d     = touched_q;
    status_d      = status_q;
    xl_ok_d       = xl_ok_q;
    assigned_d    = assigned_q;
    cnt_we        = 1'b0;
    frm_we        = 1'b0;

    unique case (state_q)
      pat_pkg::S_IDLE: begin
        if (req_fire) begin
          state_d = pat_pkg::S_LOOKUP;
        end
      end

      pat_pkg::S_LOOKUP: begin
        state_d    = pat_pkg::S_RESULT;
        status_d   = pat_pkg::ST_INVALID;
        xl_ok_d    = 1'b0;
        assigned_d = '0;
        case (item_q.cmd)
          pat_pkg::CMD_ALLOC: begin
            if (slots_gone) begin
              status_d = pat_pkg::ST_FULL;
            end else if (too_big) begin
              status_d = pat_pkg::ST_INVALID;
            end else if (no_frames) begin
              // refused: flag goes sticky, slot stays at zero pages
              status_d  = pat_pkg::ST_FULL;
              full_d    = 1'b1;
              touched_d = 1'b1;
            end else begin
              status_d      = pat_pkg::ST_OK;
              cnt_we        = 1'b1;
              frames_left_d = frames_left_q - item_q.value;
              assigned_d    = pat_pkg::PidW'(next_q);
              next_d        = next_q + NextW'(1);
              touched_d     = 1'b1;
            end
          end
          pat_pkg::CMD_WRITE: begin
            if (pid_ok && page_ok) begin
              status_d = pat_pkg::ST_OK;
              frm_we   = 1'b1;
            end
          end
          pat_pkg::CMD_XLATE: begin
            if (pid_ok && page_ok && off_ok) begin
              status_d = pat_pkg::ST_OK;
              xl_ok_d  = 1'b1;
            end
          end
          default: begin
            status_d = pat_pkg::ST_INVALID;
          end
        endcase
      end

      pat_pkg::S_RESULT: begin
        if (out_load) begin
          state_d = pat_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pat_pkg::S_IDLE;
      end
    endcase

    // frame_count reloads the pool only before the first allocate is granted or refused for lack of frames
    if (cfg_fire && (cfg_i.index == pat_pkg::CFG_FRAME_COUNT) && !touched_q) begin
      frames_left_d = cfg_i.data[pat_pkg::FrameW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pat_pkg::S_IDLE;
      page_size_q   <= pat_pkg::PageSizeRst;
      frames_left_q <= pat_pkg::FrameCountRst;
      next_q        <= '0;
      full_q        <= 1'b0;
      touched_q     <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      frames_left_q <= frames_left_d;
      next_q        <= next_d;
      full_q        <= full_d;
      touched_q     <= touched_d;
      if (cfg_fire) begin
        case (cfg_i.index)
          pat_pkg::CFG_PAGE_SIZE: page_size_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      item_q.cmd         <= req_i.cmd;
      item_q.process_id  <= req_i.process_id;
      item_q.page_number <= req_i.page_number;
      item_q.value       <= req_i.value;
      item_q.offset      <= req_i.offset;
    end
    status_q   <= status_d;
    xl_ok_q    <= xl_ok_d;
    assigned_q <= assigned_d;
    if (state_q == pat_pkg::S_LOOKUP) begin
      prod_q <= ProdW'(frm_rdata) * ProdW'(page_size_q);
    end
    if (out_load) begin
      out_status_q   <= status_q;
      out_addr_q     <= xl_ok_q ? pat_pkg::AddrW'(prod_q + ProdW'(item_q.offset)) : '0;
      out_assigned_q <= assigned_q;
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.physical_address = out_addr_q;
  assign rsp_o.assigned_process = out_assigned_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_next_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= NextW'(MAX_PROCESSES))
    else $error("process counter beyond slot count");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("memory full flag cleared");

  a_pool_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    touched_q |=> frames_left_q <= $past(frames_left_q))
    else $error("free frames grew after first allocate");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == pat_pkg::S_LOOKUP) && !req_i.ready)
    else $error("command accepted while another in flight");

  a_table_write_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we || frm_we) |-> (state_q == pat_pkg::S_LOOKUP) && !(cnt_we && frm_we))
    else $error("table write outside lookup cycle");

endmodule
